// ----- src/sgc_pkg.sv -----
// shared types and constants of the scan gap clusterer
`default_nettype none
package sgc_pkg;

    localparam int unsigned MAX_SECTOR_STEPS = 512;

    localparam int RANGE_W = 16;
    localparam int CNT_W   = 11;
    localparam int SUM_W   = 21;
    localparam int OFF_W   = 11;
    localparam int BEAR_W  = 15;
    localparam int ABS_W   = 14;
    localparam int DVD_W   = SUM_W + 4;

    localparam logic [CNT_W-1:0] COUNT_MAX   = '1;
    localparam logic [ABS_W-1:0] BEARING_LIM = ABS_W'(8192);

    // power of two, pointers wrap
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);

    localparam logic KIND_CLUSTER = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [1:0] REG_GAP    = 2'd0;
    localparam logic [1:0] REG_MINPTS = 2'd1;
    localparam logic [1:0] REG_LOWER  = 2'd2;
    localparam logic [1:0] REG_UPPER  = 2'd3;

    typedef struct packed {
        logic [RANGE_W-1:0] gap_threshold;
        logic [CNT_W-1:0]   min_cluster_points;
        logic [RANGE_W-1:0] range_lower;
        logic [RANGE_W-1:0] range_upper;
    } cfg_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [CNT_W-1:0]        count;
        logic [RANGE_W-1:0]      min_range;
    } cluster_t;

    typedef struct packed {
        logic     c0_valid;
        cluster_t c0;
        logic     c1_valid;
        cluster_t c1;
        logic     summary;
    } job_t;

endpackage
`default_nettype wire

// ----- src/sgc_in_if.sv -----
// sample channel interface
`default_nettype none
interface sgc_in_if;
    logic                                valid;
    logic                                ready;
    logic [sgc_pkg::RANGE_W-1:0]         range_mm;
    logic                                not_finite;
    logic signed [sgc_pkg::OFF_W-1:0]    step_offset;
    logic                                scan_end;

    modport source (output valid, range_mm, not_finite, step_offset, scan_end, input ready);
    modport sink   (input valid, range_mm, not_finite, step_offset, scan_end, output ready);
endinterface
`default_nettype wire

// ----- src/sgc_out_if.sv -----
// result channel interface
`default_nettype none
interface sgc_out_if;
    logic                                valid;
    logic                                ready;
    logic                                item_kind;
    logic                                found;
    logic signed [sgc_pkg::BEAR_W-1:0]   bearing_sixteenths;
    logic [sgc_pkg::RANGE_W-1:0]         distance_mm;
    logic                                last_of_run;

    modport source (output valid, item_kind, found, bearing_sixteenths, distance_mm,
                    last_of_run, input ready);
    modport sink   (input valid, item_kind, found, bearing_sixteenths, distance_mm,
                    last_of_run, output ready);
endinterface
`default_nettype wire

// ----- src/sgc_front.sv -----
// sample classification and cluster tracking
`default_nettype none
module sgc_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  sgc_pkg::cfg_t      cfg,
    sgc_in_if.sink             in_ch,
    input  wire logic          full,
    output logic               push,
    output sgc_pkg::job_t      job
);

    localparam int SW = sgc_pkg::SUM_W;
    localparam int RW = sgc_pkg::RANGE_W;
    localparam int CW = sgc_pkg::CNT_W;
    localparam int LIM_W = 14;
    localparam logic signed [SW:0] SUM_HI = (SW+1)'(2**(SW-1) - 1);
    localparam logic signed [SW:0] SUM_LO = -(SW+1)'(2**(SW-1));
    localparam logic signed [LIM_W-1:0] SECT_LIM = LIM_W'(sgc_pkg::MAX_SECTOR_STEPS);

    logic                 open_reg, open_next;
    logic [RW-1:0]        min_reg, min_next;
    logic signed [SW-1:0] sum_reg, sum_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [RW-1:0]        prev_reg, prev_next;

    logic                    accept;
    logic signed [LIM_W-1:0] off_ext;
    logic                    in_sector;
    logic                    sample_ok;
    logic [RW-1:0]           diff;
    logic                    belongs;
    logic signed [SW:0]      sum_wide;
    logic signed [SW-1:0]    sum_sat;
    logic                    open_a;
    logic [RW-1:0]           min_a;
    logic signed [SW-1:0]    sum_a;
    logic [CW-1:0]           cnt_a;
    logic [RW-1:0]           prev_a;
    logic                    c0v;
    logic                    c1v;

    assign in_ch.ready = !full;
    assign accept      = in_ch.valid && !full;

    always_comb
    begin
        off_ext   = LIM_W'(in_ch.step_offset);
        in_sector = (off_ext <= SECT_LIM) && (off_ext >= -SECT_LIM);
        sample_ok = !in_ch.not_finite && (in_ch.range_mm >= cfg.range_lower)
                    && (in_ch.range_mm <= cfg.range_upper);
        diff      = (in_ch.range_mm > prev_reg) ? (in_ch.range_mm - prev_reg)
                                                : (prev_reg - in_ch.range_mm);
        belongs   = sample_ok && open_reg && (diff < cfg.gap_threshold);
        sum_wide  = (SW+1)'(sum_reg) + (SW+1)'(in_ch.step_offset);
        if (sum_wide > SUM_HI)
        begin
            sum_sat = SW'(SUM_HI);
        end
        else if (sum_wide < SUM_LO)
        begin
            sum_sat = SW'(SUM_LO);
        end
        else
        begin
            sum_sat = SW'(sum_wide);
        end

        open_a = open_reg;
        min_a  = min_reg;
        sum_a  = sum_reg;
        cnt_a  = cnt_reg;
        prev_a = prev_reg;
        c0v    = 1'b0;
        if (in_sector)
        begin
            if (belongs)
            begin
                if (in_ch.range_mm < min_reg)
                begin
                    min_a = in_ch.range_mm;
                end
                sum_a  = sum_sat;
                if (cnt_reg != sgc_pkg::COUNT_MAX)
                begin
                    cnt_a = cnt_reg + CW'(1);
                end
                prev_a = in_ch.range_mm;
            end
            else
            begin
                c0v = open_reg && (cnt_reg >= cfg.min_cluster_points);
                if (sample_ok)
                begin
                    open_a = 1'b1;
                    min_a  = in_ch.range_mm;
                    sum_a  = SW'(in_ch.step_offset);
                    cnt_a  = CW'(1);
                    prev_a = in_ch.range_mm;
                end
                else
                begin
                    open_a = 1'b0;
                    cnt_a  = '0;
                end
            end
        end
        c1v = in_ch.scan_end && open_a && (cnt_a >= cfg.min_cluster_points);

        job.c0_valid     = c0v;
        job.c0.sum       = sum_reg;
        job.c0.count     = cnt_reg;
        job.c0.min_range = min_reg;
        job.c1_valid     = c1v;
        job.c1.sum       = sum_a;
        job.c1.count     = cnt_a;
        job.c1.min_range = min_a;
        job.summary      = in_ch.scan_end;
        push             = accept && (c0v || c1v || in_ch.scan_end);

        open_next = open_reg;
        min_next  = min_reg;
        sum_next  = sum_reg;
        cnt_next  = cnt_reg;
        prev_next = prev_reg;
        if (accept)
        begin
            if (in_ch.scan_end)
            begin
                open_next = 1'b0;
                min_next  = '0;
                sum_next  = '0;
                cnt_next  = '0;
                prev_next = '0;
            end
            else
            begin
                open_next = open_a;
                min_next  = min_a;
                sum_next  = sum_a;
                cnt_next  = cnt_a;
                prev_next = prev_a;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
            min_reg  <= '0;
            sum_reg  <= '0;
            cnt_reg  <= '0;
            prev_reg <= '0;
        end
        else
        begin
            open_reg <= open_next;
            min_reg  <= min_next;
            sum_reg  <= sum_next;
            cnt_reg  <= cnt_next;
            prev_reg <= prev_next;
        end
    end

endmodule
`default_nettype wire

// ----- src/sgc_fifo.sv -----
// job queue between front and back
`default_nettype none
module sgc_fifo (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  sgc_pkg::job_t push_data,
    output logic          full,
    input  wire logic     pop,
    output sgc_pkg::job_t pop_data,
    output logic          empty
);

    localparam int PW = sgc_pkg::PTR_W;

    sgc_pkg::job_t  mem_reg [sgc_pkg::FIFO_DEPTH];
    logic [PW-1:0]  head_reg;
    logic [PW-1:0]  tail_reg;
    logic [PW:0]    count_reg;

    assign full     = (count_reg == (PW+1)'(sgc_pkg::FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[head_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[tail_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                tail_reg <= tail_reg + PW'(1);
            end
            if (pop)
            begin
                head_reg <= head_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + (PW+1)'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - (PW+1)'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ----- src/sgc_div.sv -----
// bit-serial restoring divider for the mean bearing
`default_nettype none
module sgc_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [sgc_pkg::DVD_W-1:0]    dividend,
    input  wire logic [sgc_pkg::CNT_W-1:0]    divisor,
    output logic                              done,
    output logic [sgc_pkg::DVD_W-1:0]         quotient
);

    localparam int DW     = sgc_pkg::DVD_W;
    localparam int CW     = sgc_pkg::CNT_W;
    localparam int STEP_W = $clog2(DW);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CW-1:0]     rem_reg;
    logic [DW-1:0]     quo_reg;
    logic [CW-1:0]     dsr_reg;

    logic [CW:0]   trial;
    logic [CW:0]   trial_sub;
    logic          ge;
    logic [CW-1:0] rem_step;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[DW-1]};
        ge        = (trial >= {1'b0, dsr_reg});
        trial_sub = trial - {1'b0, dsr_reg};
        rem_step  = ge ? trial_sub[CW-1:0] : trial[CW-1:0];
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_step;
            quo_reg <= {quo_reg[DW-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ----- src/sgc_back.sv -----
// result sequencing, best-ahead tracking and output register
`default_nettype none
module sgc_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          empty,
    input  sgc_pkg::job_t                      pop_data,
    output logic                               pop,
    output logic                               div_start,
    output logic [sgc_pkg::DVD_W-1:0]          div_dividend,
    output logic [sgc_pkg::CNT_W-1:0]          div_divisor,
    input  wire logic                          div_done,
    input  wire logic [sgc_pkg::DVD_W-1:0]     div_quotient,
    sgc_out_if.source                          out_ch
);

    localparam int RW = sgc_pkg::RANGE_W;
    localparam int BW = sgc_pkg::BEAR_W;
    localparam int AW = sgc_pkg::ABS_W;
    localparam int SW = sgc_pkg::SUM_W;
    localparam int DW = sgc_pkg::DVD_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    localparam logic [1:0] PH_C0  = 2'd0;
    localparam logic [1:0] PH_C1  = 2'd1;
    localparam logic [1:0] PH_SUM = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [1:0]        phase_reg, phase_next;
    sgc_pkg::job_t     job_reg;
    logic              best_found_reg;
    logic [AW-1:0]     best_abs_reg;
    logic signed [BW-1:0] best_bear_reg;
    logic [RW-1:0]     best_dist_reg;

    logic              ovalid_reg;
    logic              okind_reg;
    logic              ofound_reg;
    logic signed [BW-1:0] obear_reg;
    logic [RW-1:0]     odist_reg;
    logic              olast_reg;

    sgc_pkg::cluster_t sel;
    logic              sel_neg;
    logic [SW-1:0]     sel_mag;
    logic [AW-1:0]     q_sat;
    logic signed [BW-1:0] bearing;
    logic              out_free;
    logic              emit;
    logic              res_last;
    logic              take_best;

    always_comb
    begin
        sel          = (phase_reg == PH_C0) ? job_reg.c0 : job_reg.c1;
        sel_neg      = sel.sum[SW-1];
        sel_mag      = sel_neg ? SW'(-sel.sum) : SW'(sel.sum);
        div_dividend = {sel_mag, 4'b0000} + DW'(sel.count >> 1);
        div_divisor  = sel.count;
        q_sat        = (div_quotient > DW'(sgc_pkg::BEARING_LIM))
                       ? sgc_pkg::BEARING_LIM : div_quotient[AW-1:0];
        bearing      = sel_neg ? -BW'(q_sat) : BW'(q_sat);
        take_best    = !best_found_reg || (q_sat < best_abs_reg);
        out_free     = !ovalid_reg || out_ch.ready;

        case (phase_reg)
            PH_C0:   res_last = !job_reg.c1_valid && !job_reg.summary;
            PH_C1:   res_last = !job_reg.summary;
            default: res_last = 1'b1;
        endcase

        pop        = 1'b0;
        div_start  = 1'b0;
        emit       = 1'b0;
        state_next = state_reg;
        phase_next = phase_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    phase_next = PH_C0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                case (phase_reg)
                    PH_C0:
                    begin
                        if (job_reg.c0_valid)
                        begin
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                        else
                        begin
                            phase_next = PH_C1;
                        end
                    end
                    PH_C1:
                    begin
                        if (job_reg.c1_valid)
                        begin
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                        else
                        begin
                            phase_next = PH_SUM;
                        end
                    end
                    default:
                    begin
                        state_next = job_reg.summary ? ST_OUT : ST_IDLE;
                    end
                endcase
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            default:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    case (phase_reg)
                        PH_C0:
                        begin
                            phase_next = PH_C1;
                            state_next = ST_LOAD;
                        end
                        PH_C1:
                        begin
                            phase_next = PH_SUM;
                            state_next = ST_LOAD;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
        endcase
    end

    assign out_ch.valid              = ovalid_reg;
    assign out_ch.item_kind          = okind_reg;
    assign out_ch.found              = ofound_reg;
    assign out_ch.bearing_sixteenths = obear_reg;
    assign out_ch.distance_mm        = odist_reg;
    assign out_ch.last_of_run        = olast_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= pop_data;
        end
        if (emit)
        begin
            olast_reg <= res_last;
            if (phase_reg == PH_SUM)
            begin
                okind_reg  <= sgc_pkg::KIND_SUMMARY;
                ofound_reg <= best_found_reg;
                obear_reg  <= best_bear_reg;
                odist_reg  <= best_dist_reg;
            end
            else
            begin
                okind_reg  <= sgc_pkg::KIND_CLUSTER;
                ofound_reg <= 1'b0;
                obear_reg  <= bearing;
                odist_reg  <= sel.min_range;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            phase_reg      <= PH_C0;
            ovalid_reg     <= 1'b0;
            best_found_reg <= 1'b0;
            best_abs_reg   <= '0;
            best_bear_reg  <= '0;
            best_dist_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            if (emit)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                ovalid_reg <= 1'b0;
            end
            if (emit)
            begin
                if (phase_reg == PH_SUM)
                begin
                    best_found_reg <= 1'b0;
                    best_abs_reg   <= '0;
                    best_bear_reg  <= '0;
                    best_dist_reg  <= '0;
                end
                else if (take_best)
                begin
                    best_found_reg <= 1'b1;
                    best_abs_reg   <= q_sat;
                    best_bear_reg  <= bearing;
                    best_dist_reg  <= sel.min_range;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ----- src/scan_gap_clusterer.sv -----
// top level: range-jump clustering of one lidar scan sector
// throughput: one sample per cycle while the four-entry job queue has room
// a sample that closes no cluster and does not end the scan produces nothing
// reported cluster: queued as a job, popped by the back end, divided by the 25-step bearing divider, then registered
// end-of-scan summary: emitted after any cluster results of that sample
// reset: rst_n clears cluster, best-ahead and queue state at once and loads register defaults
`default_nettype none
module scan_gap_clusterer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    sgc_in_if.sink           in_ch,
    sgc_out_if.source        out_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int RW = sgc_pkg::RANGE_W;
    localparam int CW = sgc_pkg::CNT_W;

    sgc_pkg::cfg_t cfg_reg;
    logic          wr_en;
    logic [1:0]    reg_idx;

    sgc_pkg::job_t                push_job;
    sgc_pkg::job_t                pop_job;
    logic                         push;
    logic                         pop;
    logic                         full;
    logic                         empty;
    logic                         div_start;
    logic                         div_done;
    logic [sgc_pkg::DVD_W-1:0]    div_dividend;
    logic [sgc_pkg::DVD_W-1:0]    div_quotient;
    logic [sgc_pkg::CNT_W-1:0]    div_divisor;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    always_comb
    begin
        case (reg_idx)
            sgc_pkg::REG_GAP:    prdata = 32'(cfg_reg.gap_threshold);
            sgc_pkg::REG_MINPTS: prdata = 32'(cfg_reg.min_cluster_points);
            sgc_pkg::REG_LOWER:  prdata = 32'(cfg_reg.range_lower);
            sgc_pkg::REG_UPPER:  prdata = 32'(cfg_reg.range_upper);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gap_threshold      <= RW'(200);
            cfg_reg.min_cluster_points <= CW'(3);
            cfg_reg.range_lower        <= '0;
            cfg_reg.range_upper        <= '1;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                sgc_pkg::REG_GAP:    cfg_reg.gap_threshold      <= pwdata[RW-1:0];
                sgc_pkg::REG_MINPTS: cfg_reg.min_cluster_points <= pwdata[CW-1:0];
                sgc_pkg::REG_LOWER:  cfg_reg.range_lower        <= pwdata[RW-1:0];
                sgc_pkg::REG_UPPER:  cfg_reg.range_upper        <= pwdata[RW-1:0];
                default:             cfg_reg.range_upper        <= cfg_reg.range_upper;
            endcase
        end
    end

    sgc_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .in_ch (in_ch),
        .full  (full),
        .push  (push),
        .job   (push_job)
    );

    sgc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_job),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_job),
        .empty     (empty)
    );

    sgc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    sgc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (empty),
        .pop_data     (pop_job),
        .pop          (pop),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_done     (div_done),
        .div_quotient (div_quotient),
        .out_ch       (out_ch)
    );

endmodule
`default_nettype wire

// ----- src/sgc_checker.sv -----
// port-level assertions for the scan gap clusterer and their bind
`default_nettype none
module sgc_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              out_valid,
    input wire logic                              out_ready,
    input wire logic                              item_kind,
    input wire logic                              found,
    input wire logic signed [sgc_pkg::BEAR_W-1:0] bearing,
    input wire logic [sgc_pkg::RANGE_W-1:0]       distance
);

    localparam logic signed [sgc_pkg::BEAR_W-1:0] B_HI = sgc_pkg::BEAR_W'(8192);
    localparam logic signed [sgc_pkg::BEAR_W-1:0] B_LO = -sgc_pkg::BEAR_W'(8192);

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result transaction dropped while stalled");

    a_cluster_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (item_kind == sgc_pkg::KIND_CLUSTER) |-> !found)
        else $error("cluster result with found set");

    a_empty_summary: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (item_kind == sgc_pkg::KIND_SUMMARY) && !found
        |-> (bearing == '0) && (distance == '0))
        else $error("empty summary carries data");

    a_bearing_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (bearing <= B_HI) && (bearing >= B_LO))
        else $error("bearing out of range");

endmodule

bind scan_gap_clusterer sgc_checker u_sgc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .item_kind (out_ch.item_kind),
    .found     (out_ch.found),
    .bearing   (out_ch.bearing_sixteenths),
    .distance  (out_ch.distance_mm)
);
`default_nettype wire

// ----- dv/scan_gap_clusterer_tb.sv -----
// testbench for scan_gap_clusterer: directed and random scans checked against a cluster predictor
`timescale 1ns / 100ps
module scan_gap_clusterer_tb;

    localparam int CLK_PERIOD     = 20;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SHOWN_LIMIT    = 10;

    localparam int RW = sgc_pkg::RANGE_W;
    localparam int CW = sgc_pkg::CNT_W;
    localparam int SW = sgc_pkg::SUM_W;
    localparam int OW = sgc_pkg::OFF_W;
    localparam int BW = sgc_pkg::BEAR_W;
    localparam int AW = sgc_pkg::ABS_W;

    typedef struct packed {
        logic                 kind;
        logic                 found;
        logic signed [BW-1:0] bearing;
        logic [RW-1:0]        distance;
        logic                 last;
    } report_t;

    class cluster_tracker_t;
        logic [RW-1:0]        gap_threshold = 16'd200;
        logic [CW-1:0]        least_points  = 11'd3;
        logic [RW-1:0]        range_lower   = 16'd0;
        logic [RW-1:0]        range_upper   = 16'hFFFF;

        bit                   open;
        logic [RW-1:0]        min_range;
        logic signed [SW-1:0] sum;
        logic [CW-1:0]        count;
        logic [RW-1:0]        prev_range;
        bit                   best_found;
        logic [AW-1:0]        best_abs;
        logic signed [BW-1:0] best_bearing;
        logic [RW-1:0]        best_distance;

        report_t              pending[$];
        int unsigned          errors;
        int unsigned          checked;
        int unsigned          samples;

        function void set_register(logic [1:0] idx, logic [31:0] value);
            case (idx)
                sgc_pkg::REG_GAP:    gap_threshold = value[RW-1:0];
                sgc_pkg::REG_MINPTS: least_points  = value[CW-1:0];
                sgc_pkg::REG_LOWER:  range_lower   = value[RW-1:0];
                sgc_pkg::REG_UPPER:  range_upper   = value[RW-1:0];
                default: ;
            endcase
        endfunction

        function void clear_scan();
            open          = 1'b0;
            min_range     = '0;
            sum           = '0;
            count         = '0;
            prev_range    = '0;
            best_found    = 1'b0;
            best_abs      = '0;
            best_bearing  = '0;
            best_distance = '0;
        endfunction

        function logic signed [BW-1:0] mean_bearing();
            longint num;
            longint mag;
            longint cnt;
            longint q;
            num = longint'(sum) * 16;
            mag = (num < 0) ? -num : num;
            cnt = (count != 0) ? longint'(count) : 64'sd1;
            q   = (mag + cnt / 2) / cnt;
            if (q > longint'(sgc_pkg::BEARING_LIM))
                q = longint'(sgc_pkg::BEARING_LIM);
            return (num < 0) ? BW'(-q) : BW'(q);
        endfunction

        function void report_open();
            logic signed [BW-1:0] b;
            logic [AW-1:0]        a;
            report_t              rep;
            if (open && count >= least_points)
            begin
                b   = mean_bearing();
                a   = (b < 0) ? AW'(-b) : AW'(b);
                rep = '{sgc_pkg::KIND_CLUSTER, 1'b0, b, min_range, 1'b0};
                pending.insert(pending.size(), rep);
                if (!best_found || a < best_abs)
                begin
                    best_found    = 1'b1;
                    best_abs      = a;
                    best_bearing  = b;
                    best_distance = min_range;
                end
            end
        endfunction

        function void take_sample(logic [RW-1:0] r, logic nf,
                                  logic signed [OW-1:0] off, logic se);
            int          o;
            int          s;
            int unsigned jump;
            bit          usable;
            int          queued;
            report_t     rep;
            queued = pending.size();
            samples++;
            o = int'(off);
            if (((o < 0) ? -o : o) <= int'(sgc_pkg::MAX_SECTOR_STEPS))
            begin
                usable = !nf && r >= range_lower && r <= range_upper;
                jump   = (r > prev_range) ? 32'(r - prev_range) : 32'(prev_range - r);
                if (usable && open && jump < gap_threshold)
                begin
                    if (r < min_range)
                        min_range = r;
                    s = sum + o;
                    if (s > 1048575)
                        s = 1048575;
                    if (s < -1048576)
                        s = -1048576;
                    sum = SW'(s);
                    if (count != sgc_pkg::COUNT_MAX)
                        count++;
                    prev_range = r;
                end
                else
                begin
                    report_open();
                    if (usable)
                    begin
                        open       = 1'b1;
                        min_range  = r;
                        sum        = SW'(o);
                        count      = 11'd1;
                        prev_range = r;
                    end
                    else
                    begin
                        open  = 1'b0;
                        count = '0;
                    end
                end
            end
            if (se)
            begin
                report_open();
                rep = '{sgc_pkg::KIND_SUMMARY, best_found,
                        best_found ? best_bearing : '0,
                        best_found ? best_distance : '0, 1'b0};
                pending.insert(pending.size(), rep);
                clear_scan();
            end
            if (pending.size() > queued)
                pending[pending.size() - 1].last = 1'b1;
        endfunction

        function string show(report_t x);
            return $sformatf("kind %0d found %0d bearing %0d distance %0d last %0d",
                             x.kind, x.found, x.bearing, x.distance, x.last);
        endfunction

        function void check_report(report_t got);
            report_t want;
            checked++;
            if (pending.size() == 0)
            begin
                if (errors < SHOWN_LIMIT)
                    $display("%0t unexpected result: %s", $time, show(got));
                errors++;
            end
            else
            begin
                want = pending.pop_front();
                if (got.kind !== want.kind || got.found !== want.found ||
                    got.bearing !== want.bearing || got.distance !== want.distance ||
                    got.last !== want.last)
                begin
                    if (errors < SHOWN_LIMIT)
                        $display("%0t mismatch: expected %s, got %s", $time,
                                 show(want), show(got));
                    errors++;
                end
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    wire  [31:0] prdata;
    wire         pready;

    int unsigned send_idle_pct;
    int unsigned stall_pct;
    int unsigned hold_len;

    cluster_tracker_t tracker;

    sgc_in_if  sample_ch();
    sgc_out_if report_ch();

    scan_gap_clusterer dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (sample_ch),
        .out_ch  (report_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && sample_ch.valid && sample_ch.ready)
            tracker.take_sample(sample_ch.range_mm, sample_ch.not_finite,
                                sample_ch.step_offset, sample_ch.scan_end);
        if (rst_n && report_ch.valid && report_ch.ready)
            tracker.check_report('{report_ch.item_kind, report_ch.found,
                                   report_ch.bearing_sixteenths, report_ch.distance_mm,
                                   report_ch.last_of_run});
    end

    initial
    begin : result_sink
        int unsigned held;
        report_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_len != 0)
            begin
                report_ch.ready <= 1'b0;
                held = 0;
                while (held < hold_len)
                begin
                    @(posedge clk);
                    held++;
                end
                hold_len = 0;
            end
            else
                report_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || psel || (sample_ch.valid && sample_ch.ready) ||
                (report_ch.valid && report_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("scan_gap_clusterer_tb: errors");
        $finish;
    end

    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        tracker.set_register(idx, value);
    endtask

    task automatic configure(input int unsigned gap, input int unsigned minpts,
                             input int unsigned lower, input int unsigned upper);
        write_register(sgc_pkg::REG_GAP, gap);
        write_register(sgc_pkg::REG_MINPTS, minpts);
        write_register(sgc_pkg::REG_LOWER, lower);
        write_register(sgc_pkg::REG_UPPER, upper);
    endtask

    task automatic send_sample(input logic [RW-1:0] r, input logic nf,
                               input logic signed [OW-1:0] off, input logic se);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid       <= 1'b1;
        sample_ch.range_mm    <= r;
        sample_ch.not_finite  <= nf;
        sample_ch.step_offset <= off;
        sample_ch.scan_end    <= se;
        do
            @(posedge clk);
        while (!sample_ch.ready);
    endtask

    task automatic drain();
        sample_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.pending.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic steady_run(input int unsigned r, input int unsigned n,
                              input int first_off, input int rest_off, input logic se);
        int unsigned i;
        for (i = 0; i < n; i++)
            send_sample(RW'(r), 1'b0, OW'((i == 0) ? first_off : rest_off),
                        se && (i == n - 1));
    endtask

    task automatic random_scans(input int unsigned quota);
        int unsigned sent;
        int unsigned span;
        int unsigned pick;
        int unsigned g;
        int unsigned i;
        int          r;
        int          o;
        logic        nf;
        logic signed [OW-1:0] off_bits;
        sent = 0;
        while (sent < quota)
        begin
            span = $urandom_range(12, 2);
            r    = $urandom_range(65535);
            o    = int'($urandom_range(1024)) - 512;
            for (i = 0; i < span; i++)
            begin
                g        = 32'(tracker.gap_threshold);
                pick     = $urandom_range(99);
                nf       = 1'b0;
                off_bits = OW'(o);
                if (pick < 55)
                    r = r + int'($urandom_range(2 * g)) - int'(g);
                else if (pick < 65)
                    r = r + ($urandom_range(1) ? 1 : -1) * (int'(g) - int'($urandom_range(1)));
                else if (pick < 82)
                    r = $urandom_range(65535);
                else if (pick < 90)
                begin
                    nf = 1'b1;
                    r  = $urandom_range(65535);
                end
                else if (pick < 96)
                begin
                    case ($urandom_range(3))
                        0: r = int'(tracker.range_lower) - 1;
                        1: r = int'(tracker.range_lower);
                        2: r = int'(tracker.range_upper);
                        default: r = int'(tracker.range_upper) + 1;
                    endcase
                end
                else
                    off_bits = OW'($urandom_range(2047));
                if (r < 0)
                    r = 0;
                if (r > 65535)
                    r = 65535;
                send_sample(RW'(r), nf, off_bits, i == span - 1);
                if (int'(off_bits) >= -512 && int'(off_bits) <= 512)
                    sent++;
                o = o + int'($urandom_range(3, 1));
                if (o > 512)
                    o = -512;
            end
        end
    endtask

    initial
    begin
        int unsigned i;
        tracker                 = new();
        send_idle_pct           = 0;
        stall_pct               = 0;
        hold_len                = 0;
        rst_n                   = 1'b0;
        psel                    = 1'b0;
        penable                 = 1'b0;
        pwrite                  = 1'b0;
        paddr                   = '0;
        pwdata                  = '0;
        sample_ch.valid         = 1'b0;
        sample_ch.range_mm      = '0;
        sample_ch.not_finite    = 1'b0;
        sample_ch.step_offset   = '0;
        sample_ch.scan_end      = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: sector edges, gap boundary, skipped and non-finite samples
        configure(200, 3, 0, 65535);
        send_sample(100, 1'b0, -512, 1'b0);
        send_sample(150, 1'b0, -511, 1'b0);
        send_sample(120, 1'b0, -510, 1'b0);
        send_sample(400, 1'b0, -509, 1'b0);
        send_sample(599, 1'b0, -508, 1'b0);
        send_sample(799, 1'b0, 1000, 1'b0);
        send_sample(0, 1'b1, 0, 1'b0);
        send_sample(65535, 1'b0, 512, 1'b0);
        send_sample(65535, 1'b0, 512, 1'b0);
        send_sample(65535, 1'b0, 511, 1'b0);
        send_sample(0, 1'b0, -1024, 1'b1);
        send_sample(500, 1'b0, 0, 1'b1);
        drain();
        write_register(sgc_pkg::REG_MINPTS, 1025);
        steady_run(700, 3, 5, 5, 1'b1);
        drain();
        // zero point minimum, equal bearings, range window edges
        configure(200, 0, 1000, 2000);
        send_sample(1500, 1'b0, 3, 1'b0);
        send_sample(20000, 1'b0, -3, 1'b0);
        send_sample(999, 1'b0, 1, 1'b0);
        send_sample(1000, 1'b0, -3, 1'b0);
        send_sample(2000, 1'b0, 3, 1'b0);
        send_sample(2001, 1'b0, 4, 1'b0);
        send_sample(1200, 1'b0, -3, 1'b1);
        drain();

        // negative half rounds away from zero
        configure(200, 1, 0, 65535);
        steady_run(5000, 32, -1, 0, 1'b1);
        drain();

        configure(200, 1, 0, 65535);
        random_scans(8);
        drain();
        send_idle_pct = 87;
        configure(0, 1, 0, 65535);
        random_scans(8);
        drain();
        send_idle_pct = 0;
        stall_pct     = 87;
        configure(65535, 2, 1000, 50000);
        random_scans(8);
        drain();
        send_idle_pct = 35;
        stall_pct     = 35;
        configure($urandom_range(2000, 20), $urandom_range(4, 1),
                  $urandom_range(3000), $urandom_range(65535, 40000));
        random_scans(8);
        drain();

        // results held back while samples keep coming so the job queue fills
        send_idle_pct = 0;
        stall_pct     = 0;
        configure(0, 1, 0, 65535);
        hold_len = 300;
        for (i = 0; i < 16; i++)
            send_sample(RW'(1000 * i), 1'b0, OW'(int'(i) - 8), i == 15);
        drain();

        if (tracker.pending.size() != 0)
        begin
            $display("%0d expected results never arrived", tracker.pending.size());
            tracker.errors += tracker.pending.size();
        end
        $display("run covered %0d samples and %0d results over directed, rounding,",
                 tracker.samples, tracker.checked);
        $display("four idle/stall mixes and a filled job queue; %0d mismatches",
                 tracker.errors);
        if (tracker.errors == 0)
            $display("scan_gap_clusterer_tb: clean");
        else
            $display("scan_gap_clusterer_tb: errors");
        $finish;
    end
endmodule
